// ===== sv/edfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared constants and types for the earliest-deadline-first scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 16;
  localparam int TASK_W    = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Best candidate handed from cell to cell during a scan
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] dl;
    logic              last;   // candidate has one unit of work left
  } cand_t;

endpackage

`default_nettype wire

// ===== sv/edfs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_in_if / edfs_out_if
// Valid/ready channels for task and tick beats and for result beats.
// ----------------------------------------------------------------------------
interface edfs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [edfs_pkg::TIME_W-1:0] arrival_time;
  logic [edfs_pkg::TIME_W-1:0] burst_length;
  logic [edfs_pkg::TIME_W-1:0] deadline_time;

  modport source (output valid, kind, arrival_time, burst_length, deadline_time,
                  input ready);
  modport sink   (input valid, kind, arrival_time, burst_length, deadline_time,
                  output ready);
endinterface

interface edfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [edfs_pkg::TASK_W-1:0] running_task;
  logic [edfs_pkg::TIME_W-1:0] slot_start;
  logic                        task_finished;
  logic                        deadline_missed;
  logic                        all_done;
  logic                        load_rejected;

  modport source (output valid, running_task, slot_start, task_finished,
                  deadline_missed, all_done, load_rejected, input ready);
  modport sink   (input valid, running_task, slot_start, task_finished,
                  deadline_missed, all_done, load_rejected, output ready);
endinterface

`default_nettype wire

// ===== sv/edfs_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_cell
// One task table entry; compares its task with the incoming candidate and
// hands the better one to the next cell.
// ----------------------------------------------------------------------------
module edfs_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [edfs_pkg::IDX_W-1:0]  my_idx,
  input  wire logic                        loaded,
  input  wire logic [edfs_pkg::TIME_W-1:0] cur_time,
  input  wire logic                        wr,
  input  wire logic [edfs_pkg::TIME_W-1:0] wr_arrival,
  input  wire logic [edfs_pkg::TIME_W-1:0] wr_burst,
  input  wire logic [edfs_pkg::TIME_W-1:0] wr_deadline,
  input  wire logic                        dec,
  input  wire edfs_pkg::cand_t             cand_in,
  output edfs_pkg::cand_t                  cand_out
);

  logic [edfs_pkg::TIME_W-1:0] arr_r;
  logic [edfs_pkg::TIME_W-1:0] dl_r;
  logic [edfs_pkg::TIME_W-1:0] rem_r;
  edfs_pkg::cand_t             cand_r;
  edfs_pkg::cand_t             cand_nxt;
  logic                        elig;
  logic                        take;

  assign elig = loaded && (rem_r != '0) && (arr_r <= cur_time);
  assign take = elig && (!cand_in.vld || (dl_r < cand_in.dl));

  always_comb begin
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.vld  = 1'b1;
      cand_nxt.idx  = my_idx;
      cand_nxt.dl   = dl_r;
      cand_nxt.last = (rem_r == edfs_pkg::TIME_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.vld <= 1'b0;
    end else begin
      cand_r.vld <= cand_nxt.vld;
    end
    cand_r.idx  <= cand_nxt.idx;
    cand_r.dl   <= cand_nxt.dl;
    cand_r.last <= cand_nxt.last;
  end

  // Table entry: write on load, count down when this task runs
  always_ff @(posedge clk) begin
    if (wr) begin
      arr_r <= wr_arrival;
      dl_r  <= wr_deadline;
      rem_r <= wr_burst;
    end else if (dec) begin
      rem_r <= rem_r - edfs_pkg::TIME_W'(1);
    end
  end

  assign cand_out = cand_r;

endmodule

`default_nettype wire

// ===== sv/edf_preemptive_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edf_preemptive_scheduler
// Preemptive earliest-deadline-first scheduler over a row of task cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per item. kind 0 loads a task (arrival, burst,
//   deadline) into the next free cell; tasks are numbered 1.. in load order.
//   kind 1 is a tick: the eligible task with the earliest deadline (lowest
//   number on a tie) runs one unit and time advances by one, saturating.
//   out_ch returns exactly one result beat per input beat, in order.
// Flow:
//   A load's result is registered at the accepting edge and is valid in the
//   next cycle; one load per cycle while the output register is free.
//   A tick sweeps a candidate through the MAX_TASKS cells, one cell per
//   cycle, then applies the winner and registers its result; no new item is
//   taken until the winner is applied. The length of the cell row sets how
//   long a tick takes.
// Reset:
//   Clears time, the loaded and finished counts and the control state. Cell
//   contents are not cleared; cells beyond the loaded count are never used.
// Stall:
//   A result waits in the output register while out_ch.ready is low; the
//   block holds the next item (in_ch.ready low) until the result is taken.
// ----------------------------------------------------------------------------
module edf_preemptive_scheduler (
  input  wire logic  clk,
  input  wire logic  rst_n,
  edfs_in_if.sink    in_ch,
  edfs_out_if.source out_ch
);

  localparam int N = edfs_pkg::MAX_TASKS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]                  st_r, st_nxt;
  logic [edfs_pkg::IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [edfs_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [edfs_pkg::CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [edfs_pkg::CNT_W-1:0]  fin_r, fin_nxt;

  logic                        out_vld_r, out_vld_nxt;
  logic [edfs_pkg::TASK_W-1:0] out_task_r, out_task_nxt;
  logic [edfs_pkg::TIME_W-1:0] out_start_r, out_start_nxt;
  logic                        out_fin_r, out_fin_nxt;
  logic                        out_miss_r, out_miss_nxt;
  logic                        out_done_r, out_done_nxt;
  logic                        out_rej_r, out_rej_nxt;

  logic out_free;
  logic in_go;
  logic load_go;
  logic table_full;
  logic apply_go;

  edfs_pkg::cand_t            cand_w [0:N];
  edfs_pkg::cand_t            sel;
  logic [edfs_pkg::IDX_W:0]   run_num;
  logic [edfs_pkg::TIME_W:0]  finish_time;
  logic [N-1:0]               wr_sel;
  logic [N-1:0]               dec_sel;
  logic [N-1:0]               loaded_vec;

  // Output slot is free when empty or being drained this cycle
  assign out_free   = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && out_free;
  assign in_go      = in_ch.valid && in_ch.ready;
  assign load_go    = in_go && !in_ch.kind;
  assign table_full = (loaded_r >= edfs_pkg::CNT_W'(N));
  assign apply_go   = (st_r == ST_APPLY) && out_free;

  // Winner leaves the last cell
  assign sel         = cand_w[N];
  assign run_num     = {1'b0, sel.idx} + (edfs_pkg::IDX_W + 1)'(1);
  assign finish_time = {1'b0, time_r} + (edfs_pkg::TIME_W + 1)'(1);

  assign cand_w[0] = '0;

  // Row of task cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign loaded_vec[i] = (edfs_pkg::CNT_W'(i) < loaded_r);
    assign wr_sel[i]     = load_go && !table_full &&
                           (loaded_r[edfs_pkg::IDX_W-1:0] == edfs_pkg::IDX_W'(i));
    assign dec_sel[i]    = apply_go && sel.vld && (sel.idx == edfs_pkg::IDX_W'(i));

    edfs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .my_idx      (edfs_pkg::IDX_W'(i)),
      .loaded      (loaded_vec[i]),
      .cur_time    (time_r),
      .wr          (wr_sel[i]),
      .wr_arrival  (in_ch.arrival_time),
      .wr_burst    (in_ch.burst_length),
      .wr_deadline (in_ch.deadline_time),
      .dec         (dec_sel[i]),
      .cand_in     (cand_w[i]),
      .cand_out    (cand_w[i+1])
    );
  end

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    time_nxt      = time_r;
    loaded_nxt    = loaded_r;
    fin_nxt       = fin_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_task_nxt  = out_task_r;
    out_start_nxt = out_start_r;
    out_fin_nxt   = out_fin_r;
    out_miss_nxt  = out_miss_r;
    out_done_nxt  = out_done_r;
    out_rej_nxt   = out_rej_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_go) begin
          if (in_ch.kind) begin
            // Tick: start the sweep through the cells
            st_nxt  = ST_SCAN;
            cnt_nxt = '0;
          end else begin
            // Load: append to the table unless full, answer at once
            if (!table_full) begin
              loaded_nxt = loaded_r + edfs_pkg::CNT_W'(1);
              if (in_ch.burst_length == '0) begin
                fin_nxt = fin_r + edfs_pkg::CNT_W'(1);
              end
            end
            out_vld_nxt   = 1'b1;
            out_task_nxt  = '0;
            out_start_nxt = time_r;
            out_fin_nxt   = 1'b0;
            out_miss_nxt  = 1'b0;
            out_rej_nxt   = table_full;
            out_done_nxt  = (fin_nxt == loaded_nxt);
          end
        end
      end
      ST_SCAN: begin
        // Step the counter while the candidate travels to the end of the row
        cnt_nxt = cnt_r + edfs_pkg::IDX_W'(1);
        if (cnt_r == edfs_pkg::IDX_W'(N - 1)) begin
          st_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
          if (sel.vld && sel.last) begin
            fin_nxt = fin_r + edfs_pkg::CNT_W'(1);
          end
          if (time_r != edfs_pkg::TIME_MAX) begin
            time_nxt = time_r + edfs_pkg::TIME_W'(1);
          end
          out_vld_nxt   = 1'b1;
          out_task_nxt  = sel.vld ? edfs_pkg::TASK_W'(run_num) : '0;
          out_start_nxt = time_r;
          out_fin_nxt   = sel.vld && sel.last;
          out_miss_nxt  = sel.vld && sel.last && (finish_time > {1'b0, sel.dl});
          out_rej_nxt   = 1'b0;
          out_done_nxt  = (fin_nxt == loaded_r);
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      time_r    <= '0;
      loaded_r  <= '0;
      fin_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      time_r    <= time_nxt;
      loaded_r  <= loaded_nxt;
      fin_r     <= fin_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_task_r  <= out_task_nxt;
    out_start_r <= out_start_nxt;
    out_fin_r   <= out_fin_nxt;
    out_miss_r  <= out_miss_nxt;
    out_done_r  <= out_done_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.running_task    = out_task_r;
  assign out_ch.slot_start      = out_start_r;
  assign out_ch.task_finished   = out_fin_r;
  assign out_ch.deadline_missed = out_miss_r;
  assign out_ch.all_done        = out_done_r;
  assign out_ch.load_rejected   = out_rej_r;

  // Checks
  a_fin_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r <= loaded_r)
    else $error("finished count exceeds loaded count");

  a_loaded_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= edfs_pkg::CNT_W'(N))
    else $error("loaded count exceeds table size");

  a_finish_has_task: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.task_finished) |-> (out_ch.running_task != '0))
    else $error("finish reported on an idle slot");

  a_scan_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |=> ((st_r == ST_SCAN) || (st_r == ST_APPLY)))
    else $error("scan left without applying a winner");

  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && (time_r != edfs_pkg::TIME_MAX)) |=> (time_r == $past(time_r) + 16'd1))
    else $error("time did not advance on a tick");

endmodule

`default_nettype wire

// ===== tb/edfs_slot_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edfs_slot_checker
// Monitors the task/tick and result channels of the EDF scheduler. It keeps
// its own task table and clock, predicts one result per accepted beat, and
// compares each result beat field by field in order.
// ----------------------------------------------------------------------------
package edfs_tb_pkg;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } beat_kind_e;

endpackage

module edfs_slot_checker (
  input  logic clk,
  input  logic rst_n,
  edfs_in_if   in_mon,
  edfs_out_if  out_mon,
  output int   error_count,
  output int   pending
);

  typedef struct packed {
    logic [edfs_pkg::TASK_W-1:0] running_task;
    logic [edfs_pkg::TIME_W-1:0] slot_start;
    logic                        task_finished;
    logic                        deadline_missed;
    logic                        all_done;
    logic                        load_rejected;
  } slot_rec_t;

  // Scheduler state as seen from outside
  logic [edfs_pkg::TIME_W-1:0] now_t;
  int unsigned                 n_loaded;
  int unsigned                 n_finished;
  logic [edfs_pkg::TIME_W-1:0] arr_q [edfs_pkg::MAX_TASKS];
  logic [edfs_pkg::TIME_W-1:0] dl_q  [edfs_pkg::MAX_TASKS];
  logic [edfs_pkg::TIME_W-1:0] rem_q [edfs_pkg::MAX_TASKS];
  bit                          done_q[edfs_pkg::MAX_TASKS];

  slot_rec_t expected_slots[$];

  // Apply one beat to the table and return the slot it reports
  function automatic slot_rec_t schedule_beat(edfs_tb_pkg::beat_kind_e kind,
                                              logic [edfs_pkg::TIME_W-1:0] arr,
                                              logic [edfs_pkg::TIME_W-1:0] burst,
                                              logic [edfs_pkg::TIME_W-1:0] dl);
    slot_rec_t                   r;
    bit                          found;
    int                          best;
    logic [edfs_pkg::TIME_W-1:0] best_dl;
    int                          i;
    r = '0;
    r.slot_start = now_t;
    if (kind == edfs_tb_pkg::KIND_LOAD) begin
      if (n_loaded >= edfs_pkg::MAX_TASKS) begin
        r.load_rejected = 1'b1;
      end else begin
        arr_q[n_loaded]  = arr;
        dl_q[n_loaded]   = dl;
        rem_q[n_loaded]  = burst;
        done_q[n_loaded] = (burst == '0);
        if (burst == '0) n_finished++;
        n_loaded++;
      end
    end else begin
      found   = 1'b0;
      best    = 0;
      best_dl = '0;
      for (i = 0; i < n_loaded; i++) begin
        if (!done_q[i] && rem_q[i] != '0 && arr_q[i] <= now_t &&
            (!found || dl_q[i] < best_dl)) begin
          found   = 1'b1;
          best    = i;
          best_dl = dl_q[i];
        end
      end
      if (found) begin
        r.running_task = edfs_pkg::TASK_W'(best + 1);
        rem_q[best]--;
        if (rem_q[best] == '0) begin
          done_q[best]    = 1'b1;
          n_finished++;
          r.task_finished = 1'b1;
          // finish time is one past the slot start, even once time saturates
          r.deadline_missed = (({1'b0, now_t} + 17'd1) > {1'b0, dl_q[best]});
        end
      end
      if (now_t != edfs_pkg::TIME_MAX) now_t++;
    end
    r.all_done = (n_finished == n_loaded);
    return r;
  endfunction

  task automatic check_field(string name, logic [edfs_pkg::TIME_W-1:0] want,
                             logic [edfs_pkg::TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    slot_rec_t want;
    if (!rst_n) begin
      now_t      = '0;
      n_loaded   = 0;
      n_finished = 0;
      expected_slots.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_slots.size() == 0) begin
          $error("result beat with no slot pending");
          error_count++;
        end else begin
          want = expected_slots.pop_front();
          check_field("running_task", want.running_task, out_mon.running_task);
          check_field("slot_start", want.slot_start, out_mon.slot_start);
          check_field("task_finished", want.task_finished, out_mon.task_finished);
          check_field("deadline_missed", want.deadline_missed, out_mon.deadline_missed);
          check_field("all_done", want.all_done, out_mon.all_done);
          check_field("load_rejected", want.load_rejected, out_mon.load_rejected);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_slots.push_back(schedule_beat(edfs_tb_pkg::beat_kind_e'(in_mon.kind),
                                               in_mon.arrival_time,
                                               in_mon.burst_length,
                                               in_mon.deadline_time));
    end
    pending = expected_slots.size();
  end

endmodule

// ===== tb/edf_preemptive_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edf_preemptive_scheduler_test
// Drives task loads and ticks into the EDF scheduler under several traffic
// patterns and lets edfs_slot_checker predict and compare every result beat.
// A directed opening covers idle slots, zero bursts, ties, preemption and
// misses; random loads and ticks follow; a closing tick run with no idling
// works off what is left in the table.
// ----------------------------------------------------------------------------
module edf_preemptive_scheduler_test;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 7;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat before giving up
  localparam int PHASE_ITEMS  = 100;
  localparam int TAIL_TICKS   = 20;    // closing ticks with no idling

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  edfs_in_if  in_ch();
  edfs_out_if out_ch();

  int error_count;
  int pending;

  // Traffic knobs: percent of cycles the sender idles / the receiver stalls
  int idle_pct  = 0;
  int stall_pct = 0;
  int idle_by_phase [4] = '{0, 81, 0, 19};
  int stall_by_phase[4] = '{0, 0, 81, 19};

  // Stimulus bookkeeping: scheduler time as implied by the ticks sent
  logic [edfs_pkg::TIME_W-1:0] now_est      = '0;
  int                          loads_sent   = 0;
  int                          quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  edf_preemptive_scheduler DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  edfs_slot_checker slot_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .error_count(error_count),
    .pending    (pending)
  );

  // Receiver: drop ready at random, at the rate of the current phase
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Present one beat and hold it until accepted. Entered and left at a falling
  // edge, so valid gets exactly one assignment per step.
  task automatic send_beat(edfs_tb_pkg::beat_kind_e kind,
                           logic [edfs_pkg::TIME_W-1:0] arr,
                           logic [edfs_pkg::TIME_W-1:0] burst,
                           logic [edfs_pkg::TIME_W-1:0] dl);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.arrival_time  <= arr;
    in_ch.burst_length  <= burst;
    in_ch.deadline_time <= dl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Task fields are don't-care on a tick: fill them with noise
  task automatic send_tick();
    send_beat(edfs_tb_pkg::KIND_TICK, edfs_pkg::TIME_W'($urandom),
              edfs_pkg::TIME_W'($urandom), edfs_pkg::TIME_W'($urandom));
    if (now_est != edfs_pkg::TIME_MAX) now_est++;
  endtask

  task automatic send_load(logic [edfs_pkg::TIME_W-1:0] arr,
                           logic [edfs_pkg::TIME_W-1:0] burst,
                           logic [edfs_pkg::TIME_W-1:0] dl);
    send_beat(edfs_tb_pkg::KIND_LOAD, arr, burst, dl);
    loads_sent++;
  endtask

  // Mostly well-formed tasks that arrive soon and compete for the near
  // future; the rest are noise with random arrivals and random deadlines.
  // Bursts stay short so most tasks finish within the run.
  task automatic send_random_task();
    logic [edfs_pkg::TIME_W-1:0] arr;
    logic [edfs_pkg::TIME_W-1:0] burst;
    logic [edfs_pkg::TIME_W-1:0] dl;
    if ($urandom_range(9) < 8) begin
      arr   = now_est + edfs_pkg::TIME_W'($urandom_range(15));
      burst = edfs_pkg::TIME_W'($urandom_range(6, 1));
      dl    = arr + edfs_pkg::TIME_W'($urandom_range(30));
    end else begin
      arr   = edfs_pkg::TIME_W'($urandom);
      burst = edfs_pkg::TIME_W'($urandom_range(7));
      dl    = edfs_pkg::TIME_W'($urandom_range(edfs_pkg::TIME_MAX - 1));
    end
    send_load(arr, burst, dl);
  endtask

  // Hold off the sender until every result is back, then switch traffic
  task automatic set_traffic(int idle, int stall);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    @(negedge clk);
  endtask

  initial begin
    int phase;

    in_ch.valid         = 1'b0;
    in_ch.kind          = edfs_tb_pkg::KIND_LOAD;
    in_ch.arrival_time  = '0;
    in_ch.burst_length  = '0;
    in_ch.deadline_time = '0;
    out_ch.ready        = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed opening, no idling ----
    send_tick();                                   // empty table: idle, all done
    send_load(16'd0, 16'd0, 16'd0);                // zero burst: done at load
    send_tick();                                   // zero-burst task never runs
    send_load(edfs_pkg::TIME_MAX, 16'd2, edfs_pkg::TIME_MAX); // arrives after the run
    send_load(16'd0, 16'd1, 16'd0);                // runs once and misses
    send_tick();
    send_load(16'd0, 16'd3, 16'd20);               // tie with the next one
    send_load(16'd0, 16'd2, 16'd20);
    send_load(16'd5, 16'd1, 16'd6);                // arrives late, preempts
    send_load(16'd0, edfs_pkg::TIME_MAX, edfs_pkg::TIME_MAX); // background task
    repeat (7) send_tick();                        // tie, preempt, finish on deadline

    // ---- Random loads and ticks under each traffic pattern ----
    for (phase = 0; phase < 4; phase++) begin
      set_traffic(idle_by_phase[phase], stall_by_phase[phase]);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 5) send_random_task();
        else send_tick();
      end
    end

    // Make sure the table overflows a few times
    while (loads_sent < edfs_pkg::MAX_TASKS + 3) send_random_task();

    // ---- Closing tick run with no idling ----
    set_traffic(0, 0);
    repeat (TAIL_TICKS) send_tick();

    // Drain and allow a tick's worth of cycles for any stray beat
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (edfs_pkg::MAX_TASKS + 4) @(negedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/edfs_pkg.sv
sv/edfs_if.sv
sv/edfs_cell.sv
sv/edf_preemptive_scheduler.sv
tb/edfs_slot_checker.sv
tb/edf_preemptive_scheduler_test.sv
